// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file nrmc_checker.sv.
// Each macro expects signals clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/nrmc_pkg.sv -----
// Shared constants for the NMEA sentence field extractor.
// Result kind codes, register map and ASCII codes; no dependencies.
package nrmc_pkg;

	// result kinds
	localparam logic [1:0] KIND_FIRST  = 2'd0;
	localparam logic [1:0] KIND_SECOND = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// register map: index = paddr[4:3]
	localparam int unsigned ADDR_W = 5;
	localparam logic [1:0] REG_TAG    = 2'd0;
	localparam logic [1:0] REG_FIRST  = 2'd1;
	localparam logic [1:0] REG_SECOND = 2'd2;

	localparam logic [39:0] TAG_RESET    = 40'h4750524D43; // "GPRMC"
	localparam logic [3:0]  FIRST_RESET  = 4'd3;
	localparam logic [3:0]  SECOND_RESET = 4'd5;

	// characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// '$' plus five tag characters
	localparam int unsigned HEADER_LEN = 6;
	localparam logic [3:0]  COMMA_SAT  = 4'd15;

endpackage

// ----- design/nmea_rmc_position_extractor.sv -----
// NMEA sentence field extractor, top level.
// Uses nrmc_pkg; single module, checker is bound from nrmc_checker.sv.
//
// Usage:
//  - Input channel (in_valid / in_stall / rx_byte): one received character per
//    word. A word is taken at a clock edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall / kind ...): one word per field
//    character of a matching sentence (kind first or second), and one done
//    word at the line end of a matching sentence.
//  - APB port: sentence_tag at 0x00 (64-bit data, low 40 bits used),
//    first_field_index at 0x08, second_field_index at 0x10. Write only while
//    idle. pready is tied high.
// Timing:
//  - One word per cycle while out_stall is low. A character is held in the input
//    register, is decoded against the sentence state, and any result lands in
//    the output register, which drives out_valid.
//  - out_stall holds the output register; the input register then fills and
//    in_stall rises, so nothing is lost.
// Reset: arst_n clears the sentence state (outside a sentence) and loads the
//    register defaults (tag "GPRMC", fields 3 and 5).
module nmea_rmc_position_extractor
	import nrmc_pkg::*;
#(
	parameter int SENTENCE_MAX = 128,
	parameter int FIELD_MAX    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	// input words
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	// output words
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [7:0]          char_value,
	output logic [3:0]          char_pos,
	output logic [4:0]          first_len,
	output logic [4:0]          second_len,
	output logic                first_found,
	output logic                second_found,
	output logic                truncated
);

	// stored_count holds up to SENTENCE_MAX-1
	localparam int unsigned CNT_W = $clog2(SENTENCE_MAX);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SENTENCE_MAX - 1);
	localparam logic [CNT_W-1:0] CNT_HDR   = CNT_W'(HEADER_LEN);
	localparam logic [CNT_W-1:0] TAG_LAST  = CNT_W'(HEADER_LEN - 1);
	localparam logic [4:0]       FLD_LIMIT = 5'(FIELD_MAX);

	// ---------------- configuration ----------------
	logic [39:0] tag_q;
	logic [3:0]  first_idx_q;
	logic [3:0]  second_idx_q;
	logic        cfg_wr;
	logic [1:0]  cfg_reg;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_reg = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q        <= TAG_RESET;
			first_idx_q  <= FIRST_RESET;
			second_idx_q <= SECOND_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_reg)
				REG_TAG:    tag_q        <= pwdata[39:0];
				REG_FIRST:  first_idx_q  <= pwdata[3:0];
				REG_SECOND: second_idx_q <= pwdata[3:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_reg)
			REG_TAG:    prdata = {24'd0, tag_q};
			REG_FIRST:  prdata = {60'd0, first_idx_q};
			REG_SECOND: prdata = {60'd0, second_idx_q};
			default:    prdata = 64'd0;
		endcase
	end

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// the output register can take a new word this cycle
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// ---------------- sentence state ----------------
	logic             in_sent_q;
	logic [CNT_W-1:0] stored_q;
	logic             tag_ok_q;
	logic [3:0]       comma_q;
	logic [4:0]       first_cnt_q;
	logic [4:0]       second_cnt_q;
	logic             first_seen_q;
	logic             second_seen_q;
	logic             ovf_q;

	logic             in_sent_d;
	logic [CNT_W-1:0] stored_d;
	logic             tag_ok_d;
	logic [3:0]       comma_d;
	logic [4:0]       first_cnt_d;
	logic [4:0]       second_cnt_d;
	logic             first_seen_d;
	logic             second_seen_d;
	logic             ovf_d;

	logic             res_valid;
	logic [1:0]       res_kind;
	logic [7:0]       res_char;
	logic [3:0]       res_pos;
	logic [7:0]       want;
	logic             first_hit;
	logic             second_hit;

	// expected tag character for header positions 1..5
	always_comb begin
		case (stored_q[2:0])
			3'd1:    want = tag_q[39:32];
			3'd2:    want = tag_q[31:24];
			3'd3:    want = tag_q[23:16];
			3'd4:    want = tag_q[15:8];
			3'd5:    want = tag_q[7:0];
			default: want = 8'd0;
		endcase
	end

	// field selection on the comma count before this character
	assign first_hit  = (first_idx_q != 4'd0) && (comma_q == first_idx_q);
	assign second_hit = (second_idx_q != 4'd0) && (comma_q == second_idx_q);

	always_comb begin
		in_sent_d     = in_sent_q;
		stored_d      = stored_q;
		tag_ok_d      = tag_ok_q;
		comma_d       = comma_q;
		first_cnt_d   = first_cnt_q;
		second_cnt_d  = second_cnt_q;
		first_seen_d  = first_seen_q;
		second_seen_d = second_seen_q;
		ovf_d         = ovf_q;
		res_valid     = 1'b0;
		res_kind      = KIND_DONE;
		res_char      = 8'd0;
		res_pos       = 4'd0;

		if (!in_sent_q) begin
			// hunt for the start of a sentence
			if (byte_s1 == CH_DOLLAR) begin
				in_sent_d     = 1'b1;
				stored_d      = CNT_W'(1);
				tag_ok_d      = 1'b1;
				comma_d       = 4'd0;
				first_cnt_d   = 5'd0;
				second_cnt_d  = 5'd0;
				first_seen_d  = 1'b0;
				second_seen_d = 1'b0;
				ovf_d         = 1'b0;
			end
		end else if (byte_s1 == CH_LF || byte_s1 == CH_CR) begin
			in_sent_d = 1'b0;
			// short sentences never match
			if (tag_ok_q && stored_q >= CNT_HDR) begin
				res_valid = 1'b1;
			end
		end else if (stored_q >= CNT_LIMIT) begin
			// sentence buffer full: drop character
			ovf_d = 1'b1;
		end else begin
			stored_d = stored_q + CNT_W'(1);
			if (stored_q != '0 && stored_q <= TAG_LAST) begin
				if (byte_s1 != want) begin
					tag_ok_d = 1'b0;
				end
			end else if (stored_q == '0) begin
				// not reachable inside a sentence
			end else if (byte_s1 == CH_COMMA) begin
				if (comma_q != COMMA_SAT) begin
					comma_d = comma_q + 4'd1;
				end
				if (first_idx_q != 4'd0 && comma_d == first_idx_q) begin
					first_seen_d = 1'b1;
				end
				if (second_idx_q != 4'd0 && comma_d == second_idx_q) begin
					second_seen_d = 1'b1;
				end
			end else if (first_hit) begin
				if (first_cnt_q < FLD_LIMIT) begin
					first_cnt_d = first_cnt_q + 5'd1;
					res_valid   = tag_ok_q;
					res_kind    = KIND_FIRST;
					res_char    = byte_s1;
					res_pos     = first_cnt_q[3:0];
				end else begin
					ovf_d = 1'b1;
				end
			end else if (second_hit) begin
				if (second_cnt_q < FLD_LIMIT) begin
					second_cnt_d = second_cnt_q + 5'd1;
					res_valid    = tag_ok_q;
					res_kind     = KIND_SECOND;
					res_char     = byte_s1;
					res_pos      = second_cnt_q[3:0];
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q     <= 1'b0;
			stored_q      <= '0;
			tag_ok_q      <= 1'b1;
			comma_q       <= 4'd0;
			first_cnt_q   <= 5'd0;
			second_cnt_q  <= 5'd0;
			first_seen_q  <= 1'b0;
			second_seen_q <= 1'b0;
			ovf_q         <= 1'b0;
		end else if (valid_s1 && advance) begin
			in_sent_q     <= in_sent_d;
			stored_q      <= stored_d;
			tag_ok_q      <= tag_ok_d;
			comma_q       <= comma_d;
			first_cnt_q   <= first_cnt_d;
			second_cnt_q  <= second_cnt_d;
			first_seen_q  <= first_seen_d;
			second_seen_q <= second_seen_d;
			ovf_q         <= ovf_d;
		end
	end

	// ---------------- output register ----------------
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] char_q;
	logic [3:0] pos_q;
	logic [4:0] first_len_q;
	logic [4:0] second_len_q;
	logic       first_found_q;
	logic       second_found_q;
	logic       trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	// status fields carry the counts after this character
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			kind_q         <= res_kind;
			char_q         <= res_char;
			pos_q          <= res_pos;
			first_len_q    <= first_cnt_d;
			second_len_q   <= second_cnt_d;
			first_found_q  <= first_seen_d;
			second_found_q <= second_seen_d;
			trunc_q        <= ovf_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign char_value   = char_q;
	assign char_pos     = pos_q;
	assign first_len    = first_len_q;
	assign second_len   = second_len_q;
	assign first_found  = first_found_q;
	assign second_found = second_found_q;
	assign truncated    = trunc_q;

endmodule

// ----- design/nrmc_checker.sv -----
// Port-level checker for the NMEA sentence field extractor, bound to the top.
// Uses nrmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nrmc_checker
	import nrmc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [7:0]        rx_byte,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        kind,
	input logic [7:0]        char_value,
	input logic [3:0]        char_pos,
	input logic [4:0]        first_len,
	input logic [4:0]        second_len,
	input logic              first_found,
	input logic              second_found,
	input logic              truncated
);

	logic        in_held;
	logic        out_held;
	logic [26:0] out_word;
	logic [4:0]  pos_next;

	assign in_held  = in_valid && in_stall;
	assign out_held = out_valid && out_stall;
	assign out_word = {kind, char_value, char_pos, first_len, second_len,
		first_found, second_found, truncated};
	assign pos_next = {1'b0, char_pos} + 5'd1;

	// stalled input word stays put
	`ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(rx_byte), "input word changed under stall")

	// held output word stays put
	`ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "output word changed under stall")

	// done words carry no character
	`ASSERT_SAME(a_done_clean, out_valid && kind == KIND_DONE, char_value == 8'd0 && char_pos == 4'd0, "done word with character data")

	// a first-field character is the last one counted
	`ASSERT_SAME(a_first_pos, out_valid && kind == KIND_FIRST, first_len == pos_next, "first field position and length disagree")

	// same for the second field
	`ASSERT_SAME(a_second_pos, out_valid && kind == KIND_SECOND, second_len == pos_next, "second field position and length disagree")

endmodule

bind nmea_rmc_position_extractor nrmc_checker u_nrmc_checker (.*);
